### rtl/lpg_pkg.sv
// Shared types and constants for the line point generator.
package lpg_pkg;

	localparam int COORD_BITS_DEFAULT = 12;
	localparam int COLOR_BITS = 32;

	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_SINGLE = 3'd1,
		MODE_FLAT   = 3'd2,
		MODE_VERT   = 3'd3,
		MODE_GEN    = 3'd4
	} lpg_mode_t;

	typedef struct packed {
		lpg_mode_t mode;
		logic      phase;
		logic      step_left;
		logic      step_up;
	} lpg_ctrl_t;

endpackage

### rtl/lpg_step.sv
// One rasterizer step: line setup on start, then emit a point and advance the walk.
module lpg_step #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT,
	localparam int ERR_BITS = COORD_BITS + 2
) (
	input  logic                           operation,
	input  logic [COORD_BITS-1:0]          start_x,
	input  logic [COORD_BITS-1:0]          start_y,
	input  logic [COORD_BITS-1:0]          end_x,
	input  logic [COORD_BITS-1:0]          end_y,
	input  logic [lpg_pkg::COLOR_BITS-1:0] line_color,
	input  logic [COORD_BITS-1:0]          cur_x,
	input  logic [COORD_BITS-1:0]          cur_y,
	input  logic [COORD_BITS-1:0]          tgt_x,
	input  logic [COORD_BITS-1:0]          tgt_y,
	input  logic [COORD_BITS-1:0]          abs_dx,
	input  logic [COORD_BITS-1:0]          abs_dy,
	input  logic signed [ERR_BITS-1:0]     err,
	input  logic [lpg_pkg::COLOR_BITS-1:0] held_color,
	input  lpg_pkg::lpg_ctrl_t             ctrl,
	output logic [COORD_BITS-1:0]          nxt_x,
	output logic [COORD_BITS-1:0]          nxt_y,
	output logic [COORD_BITS-1:0]          nxt_tgt_x,
	output logic [COORD_BITS-1:0]          nxt_tgt_y,
	output logic [COORD_BITS-1:0]          nxt_abs_dx,
	output logic [COORD_BITS-1:0]          nxt_abs_dy,
	output logic signed [ERR_BITS-1:0]     nxt_err,
	output logic [lpg_pkg::COLOR_BITS-1:0] nxt_color,
	output lpg_pkg::lpg_ctrl_t             nxt_ctrl,
	output logic [COORD_BITS-1:0]          point_x,
	output logic [COORD_BITS-1:0]          point_y,
	output logic [lpg_pkg::COLOR_BITS-1:0] point_color,
	output logic                           point_valid,
	output logic                           last_point
);

	logic signed [COORD_BITS:0]     dx;
	logic signed [COORD_BITS:0]     dy;
	logic [COORD_BITS-1:0]          dx_abs;
	logic [COORD_BITS-1:0]          dy_abs;
	logic [COORD_BITS:0]            dx_round;
	logic [COORD_BITS-1:0]          dx_half;
	logic signed [ERR_BITS-1:0]     err_init;
	lpg_pkg::lpg_ctrl_t             init_ctrl;

	logic [COORD_BITS-1:0]          eff_x;
	logic [COORD_BITS-1:0]          eff_y;
	logic [COORD_BITS-1:0]          eff_tx;
	logic [COORD_BITS-1:0]          eff_ty;
	logic [COORD_BITS-1:0]          eff_adx;
	logic [COORD_BITS-1:0]          eff_ady;
	logic signed [ERR_BITS-1:0]     eff_err;
	logic [lpg_pkg::COLOR_BITS-1:0] eff_color;
	lpg_pkg::lpg_ctrl_t             eff_ctrl;

	logic signed [ERR_BITS-1:0]     err_upd;
	logic                           last;
	logic                           emit;

	// line setup from the endpoints
	always_comb begin
		dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		dx_abs = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		dy_abs = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		dx_round = {1'b0, dx_abs} + (COORD_BITS + 1)'(1);
		dx_half = dx_round[COORD_BITS:1];
		// start at -ceil(|dx|/2)
		err_init = -$signed({2'b00, dx_half});
		init_ctrl.phase = 1'b0;
		init_ctrl.step_left = dx[COORD_BITS];
		init_ctrl.step_up = dy[COORD_BITS];
		if (dx_abs == '0 && dy_abs == '0) begin
			init_ctrl.mode = lpg_pkg::MODE_SINGLE;
		end else if (dy_abs == '0) begin
			init_ctrl.mode = lpg_pkg::MODE_FLAT;
		end else if (dx_abs == '0) begin
			init_ctrl.mode = lpg_pkg::MODE_VERT;
		end else begin
			init_ctrl.mode = lpg_pkg::MODE_GEN;
		end
	end

	// a start beat replaces the held line before the point is emitted
	always_comb begin
		if (operation == lpg_pkg::OP_START) begin
			eff_x = start_x;
			eff_y = start_y;
			eff_tx = end_x;
			eff_ty = end_y;
			eff_adx = dx_abs;
			eff_ady = dy_abs;
			eff_err = err_init;
			eff_color = line_color;
			eff_ctrl = init_ctrl;
		end else begin
			eff_x = cur_x;
			eff_y = cur_y;
			eff_tx = tgt_x;
			eff_ty = tgt_y;
			eff_adx = abs_dx;
			eff_ady = abs_dy;
			eff_err = err;
			eff_color = held_color;
			eff_ctrl = ctrl;
		end
	end

	always_comb begin
		nxt_x = eff_x;
		nxt_y = eff_y;
		nxt_err = eff_err;
		nxt_ctrl = eff_ctrl;
		err_upd = eff_err;
		last = 1'b0;
		emit = 1'b1;
		case (eff_ctrl.mode)
			lpg_pkg::MODE_SINGLE: begin
				last = 1'b1;
			end
			lpg_pkg::MODE_FLAT: begin
				nxt_x = eff_ctrl.step_left ? eff_x - COORD_BITS'(1) : eff_x + COORD_BITS'(1);
				last = (nxt_x == eff_tx);
			end
			lpg_pkg::MODE_VERT: begin
				nxt_y = eff_ctrl.step_up ? eff_y - COORD_BITS'(1) : eff_y + COORD_BITS'(1);
				last = (nxt_y == eff_ty);
			end
			lpg_pkg::MODE_GEN: begin
				if (eff_ctrl.phase) begin
					err_upd = eff_err - $signed({2'b00, eff_adx});
					nxt_y = eff_ctrl.step_up ? eff_y - COORD_BITS'(1) : eff_y + COORD_BITS'(1);
				end else begin
					err_upd = eff_err + $signed({2'b00, eff_ady});
				end
				nxt_err = err_upd;
				// error not positive: advance to the next column
				if (err_upd[ERR_BITS-1] || err_upd == '0) begin
					nxt_ctrl.phase = 1'b0;
					nxt_x = eff_ctrl.step_left ? eff_x - COORD_BITS'(1) : eff_x + COORD_BITS'(1);
					last = (nxt_x == eff_tx);
				end else begin
					nxt_ctrl.phase = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
				nxt_ctrl.mode = lpg_pkg::MODE_IDLE;
			end
		endcase
		if (last) begin
			nxt_ctrl.mode = lpg_pkg::MODE_IDLE;
			nxt_ctrl.phase = 1'b0;
		end
	end

	assign nxt_tgt_x = eff_tx;
	assign nxt_tgt_y = eff_ty;
	assign nxt_abs_dx = eff_adx;
	assign nxt_abs_dy = eff_ady;
	assign nxt_color = eff_color;

	assign point_x = emit ? eff_x : '0;
	assign point_y = emit ? eff_y : '0;
	assign point_color = emit ? eff_color : '0;
	assign point_valid = emit;
	assign last_point = last;

endmodule

### rtl/line_point_generator.sv
// Line point generator top level: input register, step logic, line state, result register.
//
// Input channel: in_valid / in_stall with operation, endpoints and line_color.
// A start beat (operation 0) loads a new line and yields its first point; each
// next beat (operation 1) yields the following point. Every input beat gives
// exactly one result beat on out_valid / out_stall: point_x, point_y,
// point_color, point_valid and last_point. A next beat with no line active
// gives a result with every field zero.
// A beat accepted into the input register waits there while the result register
// is full and stalled; it is then stepped into the result register and out_valid rises.
// Throughput is one beat per cycle while out_stall is low; the line state feeds
// back through a single register, which is updated with each step.
// While out_stall holds a full result register, the input register holds its
// beat and in_stall rises once it is also full; nothing is dropped.
// Reset (arst_n low) empties both registers and leaves no line active.
module line_point_generator #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [COORD_BITS-1:0]          start_x,
	input  logic [COORD_BITS-1:0]          start_y,
	input  logic [COORD_BITS-1:0]          end_x,
	input  logic [COORD_BITS-1:0]          end_y,
	input  logic [lpg_pkg::COLOR_BITS-1:0] line_color,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [COORD_BITS-1:0]          point_x,
	output logic [COORD_BITS-1:0]          point_y,
	output logic [lpg_pkg::COLOR_BITS-1:0] point_color,
	output logic                           point_valid,
	output logic                           last_point
);

	localparam int ERR_BITS = COORD_BITS + 2;

	logic                           valid_s1;
	logic                           operation_s1;
	logic [COORD_BITS-1:0]          start_x_s1;
	logic [COORD_BITS-1:0]          start_y_s1;
	logic [COORD_BITS-1:0]          end_x_s1;
	logic [COORD_BITS-1:0]          end_y_s1;
	logic [lpg_pkg::COLOR_BITS-1:0] line_color_s1;

	logic                           valid_s2;
	logic [COORD_BITS-1:0]          point_x_s2;
	logic [COORD_BITS-1:0]          point_y_s2;
	logic [lpg_pkg::COLOR_BITS-1:0] point_color_s2;
	logic                           point_valid_s2;
	logic                           last_point_s2;

	logic [COORD_BITS-1:0]          cur_x_q;
	logic [COORD_BITS-1:0]          cur_y_q;
	logic [COORD_BITS-1:0]          tgt_x_q;
	logic [COORD_BITS-1:0]          tgt_y_q;
	logic [COORD_BITS-1:0]          abs_dx_q;
	logic [COORD_BITS-1:0]          abs_dy_q;
	logic signed [ERR_BITS-1:0]     err_q;
	logic [lpg_pkg::COLOR_BITS-1:0] color_q;
	lpg_pkg::lpg_ctrl_t             ctrl_q;

	logic [COORD_BITS-1:0]          nxt_x;
	logic [COORD_BITS-1:0]          nxt_y;
	logic [COORD_BITS-1:0]          nxt_tgt_x;
	logic [COORD_BITS-1:0]          nxt_tgt_y;
	logic [COORD_BITS-1:0]          nxt_abs_dx;
	logic [COORD_BITS-1:0]          nxt_abs_dy;
	logic signed [ERR_BITS-1:0]     nxt_err;
	logic [lpg_pkg::COLOR_BITS-1:0] nxt_color;
	lpg_pkg::lpg_ctrl_t             nxt_ctrl;
	logic [COORD_BITS-1:0]          res_x;
	logic [COORD_BITS-1:0]          res_y;
	logic [lpg_pkg::COLOR_BITS-1:0] res_color;
	logic                           res_valid;
	logic                           res_last;

	logic                           step_go;
	logic                           in_take;

	// step when the result register is empty or being drained
	assign step_go = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~step_go;
	assign in_take = in_valid & ~in_stall;

	lpg_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.operation   (operation_s1),
		.start_x     (start_x_s1),
		.start_y     (start_y_s1),
		.end_x       (end_x_s1),
		.end_y       (end_y_s1),
		.line_color  (line_color_s1),
		.cur_x       (cur_x_q),
		.cur_y       (cur_y_q),
		.tgt_x       (tgt_x_q),
		.tgt_y       (tgt_y_q),
		.abs_dx      (abs_dx_q),
		.abs_dy      (abs_dy_q),
		.err         (err_q),
		.held_color  (color_q),
		.ctrl        (ctrl_q),
		.nxt_x       (nxt_x),
		.nxt_y       (nxt_y),
		.nxt_tgt_x   (nxt_tgt_x),
		.nxt_tgt_y   (nxt_tgt_y),
		.nxt_abs_dx  (nxt_abs_dx),
		.nxt_abs_dy  (nxt_abs_dy),
		.nxt_err     (nxt_err),
		.nxt_color   (nxt_color),
		.nxt_ctrl    (nxt_ctrl),
		.point_x     (res_x),
		.point_y     (res_y),
		.point_color (res_color),
		.point_valid (res_valid),
		.last_point  (res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctrl_q <= '{mode: lpg_pkg::MODE_IDLE, phase: 1'b0, step_left: 1'b0, step_up: 1'b0};
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (step_go) begin
				valid_s2 <= 1'b1;
				ctrl_q <= nxt_ctrl;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			operation_s1 <= operation;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1 <= end_x;
			end_y_s1 <= end_y;
			line_color_s1 <= line_color;
		end
		if (step_go) begin
			point_x_s2 <= res_x;
			point_y_s2 <= res_y;
			point_color_s2 <= res_color;
			point_valid_s2 <= res_valid;
			last_point_s2 <= res_last;
			cur_x_q <= nxt_x;
			cur_y_q <= nxt_y;
			tgt_x_q <= nxt_tgt_x;
			tgt_y_q <= nxt_tgt_y;
			abs_dx_q <= nxt_abs_dx;
			abs_dy_q <= nxt_abs_dy;
			err_q <= nxt_err;
			color_q <= nxt_color;
		end
	end

	assign out_valid = valid_s2;
	assign point_x = point_x_s2;
	assign point_y = point_y_s2;
	assign point_color = point_color_s2;
	assign point_valid = point_valid_s2;
	assign last_point = last_point_s2;

	// the inner y step exists only in the general walk
	a_phase_gen: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.phase |-> (ctrl_q.mode == lpg_pkg::MODE_GEN))
		else $error("inner phase set outside general mode");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room downstream");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_point) |-> point_valid)
		else $error("last point flagged on an empty result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_valid) |-> (point_x == '0 && point_y == '0 && point_color == '0))
		else $error("empty result carries data");

	a_step_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && res_last) |=> (ctrl_q.mode == lpg_pkg::MODE_IDLE))
		else $error("line still active after its last point");

endmodule
